/* design/sleep_and_quantum_tick_table_core_macros.svh */
// Assertion macros for the sleep and quantum tick table.
// Expects clk and rst_n in the scope of use.
`ifndef SLEEP_AND_QUANTUM_TICK_TABLE_CORE_MACROS_SVH
`define SLEEP_AND_QUANTUM_TICK_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define SQT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sqt: same-cycle check failed");

// next-cycle implication
`define SQT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqt: next-cycle check failed");

`endif

/* design/sqt_pkg.sv */
// Shared types and codes for the sleep and quantum tick table.
// No dependencies.
`timescale 1ns / 1ps

package sqt_pkg;

  localparam int TASK_COUNT_DEF = 16;
  localparam int TASK_ID_W      = 4;
  localparam int COUNT_W        = 32;
  localparam int OPCODE_W       = 2;
  localparam int KIND_W         = 2;

  localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SLEEP = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_START = 2'd2;

  localparam logic [KIND_W-1:0] EV_ACK    = 2'd0;
  localparam logic [KIND_W-1:0] EV_WAKE   = 2'd1;
  localparam logic [KIND_W-1:0] EV_EXPIRE = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]  opcode;
    logic [TASK_ID_W-1:0] task_id;
    logic [COUNT_W-1:0]   count_value;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0]    event_kind;
    logic [TASK_ID_W-1:0] event_task;
    logic [COUNT_W-1:0]   ticks_seen;
    logic                 last;
  } out_t;

  // sequencer to output stage: push an event, or finish the item
  typedef struct packed {
    logic                 push;
    logic                 fin;
    logic [KIND_W-1:0]    event_kind;
    logic [TASK_ID_W-1:0] event_task;
    logic [COUNT_W-1:0]   ticks;
  } cmd_t;

endpackage

/* design/sqt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sqt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/sqt_out.sv */
// Output stage: one held event plus the output register.
// Depends on sqt_pkg.
`timescale 1ns / 1ps

module sqt_out import sqt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  output logic adv,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic have_r, have_nxt;
  out_t held_r, held_nxt;
  logic take;

  // an event is only known not to be the last once the next one turns up
  assign take = out_valid_r && !out_stall;
  assign adv  = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && !take;
    out_data_nxt  = out_data_r;
    have_nxt      = have_r;
    held_nxt      = held_r;
    if (adv && cmd.push) begin
      if (have_r) begin
        out_data_nxt      = held_r;
        out_data_nxt.last = 1'b0;
        out_valid_nxt     = 1'b1;
      end
      held_nxt.event_kind = cmd.event_kind;
      held_nxt.event_task = cmd.event_task;
      held_nxt.ticks_seen = cmd.ticks;
      held_nxt.last       = 1'b0;
      have_nxt            = 1'b1;
    end else if (adv && cmd.fin) begin
      if (have_r) begin
        out_data_nxt = held_r;
      end else begin
        out_data_nxt.event_kind = EV_ACK;
        out_data_nxt.event_task = '0;
        out_data_nxt.ticks_seen = cmd.ticks;
      end
      out_data_nxt.last = 1'b1;
      out_valid_nxt     = 1'b1;
      have_nxt          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      have_r      <= have_nxt;
    end
    out_data_r <= out_data_nxt;
    held_r     <= held_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/sqt_ctrl.sv */
// Sequencer: decodes operations, walks the countdown RAM on a tick.
// Depends on sqt_pkg; drives the ports of sqt_ram.
`timescale 1ns / 1ps

module sqt_ctrl import sqt_pkg::*; #(
  parameter int TASK_COUNT = TASK_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  input  logic adv,
  output cmd_t cmd,
  output logic wr_en,
  output logic [(TASK_COUNT > 1 ? $clog2(TASK_COUNT) : 1)-1:0] wr_addr,
  output logic [COUNT_W-1:0] wr_data,
  output logic rd_en,
  output logic [(TASK_COUNT > 1 ? $clog2(TASK_COUNT) : 1)-1:0] rd_addr,
  input  logic [COUNT_W-1:0] rd_data
);

  localparam int IDX_W = TASK_COUNT > 1 ? $clog2(TASK_COUNT) : 1;
  localparam int CNT_W = $clog2(TASK_COUNT + 2);
  localparam logic [CNT_W-1:0] CNT_QUANT = CNT_W'(TASK_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } st_t;

  st_t st_r, st_nxt;
  logic [TASK_COUNT-1:0] sleep_r, sleep_nxt;
  logic cv_r, cv_nxt;
  logic [TASK_ID_W-1:0] ct_r, ct_nxt;
  logic [COUNT_W-1:0] tick_r, tick_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic pend_r, pend_nxt;
  logic pq_r, pq_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic fwd_r, fwd_nxt;
  logic [COUNT_W-1:0] fwd_data_r, fwd_data_nxt;

  logic in_acc;
  logic [IDX_W-1:0] ct_idx, tid_idx;
  logic [COUNT_W-1:0] cd;
  logic hit;

  assign in_stall = !(st_r == ST_IDLE && adv);
  assign in_acc   = in_valid && !in_stall;
  assign ct_idx   = IDX_W'(ct_r);
  assign tid_idx  = IDX_W'(in_data.task_id);
  assign cd       = fwd_r ? fwd_data_r : rd_data;
  assign hit      = pq_r || sleep_r[pidx_r];

  always_comb begin
    st_nxt       = st_r;
    sleep_nxt    = sleep_r;
    cv_nxt       = cv_r;
    ct_nxt       = ct_r;
    tick_nxt     = tick_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = pend_r;
    pq_nxt       = pq_r;
    pidx_nxt     = pidx_r;
    fwd_nxt      = fwd_r;
    fwd_data_nxt = fwd_data_r;
    wr_en        = 1'b0;
    wr_addr      = ct_idx;
    wr_data      = in_data.count_value;
    rd_en        = 1'b0;
    rd_addr      = cnt_r[IDX_W-1:0];
    cmd          = '0;
    cmd.ticks    = tick_r;

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.opcode)
            OP_TICK: begin
              tick_nxt  = tick_r + 1'b1;
              cmd.ticks = tick_nxt;
              if (cv_r) begin
                st_nxt   = ST_WALK;
                cnt_nxt  = '0;
                pend_nxt = 1'b0;
              end else begin
                cmd.fin = 1'b1;
              end
            end
            OP_SLEEP: begin
              if (cv_r) begin
                sleep_nxt[ct_idx] = 1'b1;
                wr_en             = 1'b1;
                cv_nxt            = 1'b0;
              end
              cmd.fin = 1'b1;
            end
            OP_START: begin
              if (32'(in_data.task_id) < 32'(TASK_COUNT)) begin
                sleep_nxt[tid_idx] = 1'b0;
                wr_en              = 1'b1;
                wr_addr            = tid_idx;
                ct_nxt             = in_data.task_id;
                cv_nxt             = 1'b1;
              end
              cmd.fin = 1'b1;
            end
            default: begin
              cmd.fin = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (adv) begin
          cnt_nxt = cnt_r + 1'b1;
          // retire the entry whose read data is out this cycle
          if (pend_r && hit) begin
            wr_en   = 1'b1;
            wr_addr = pidx_r;
            if (cd <= 32'd1) begin
              wr_data        = '0;
              cmd.push       = 1'b1;
              cmd.event_task = TASK_ID_W'(pidx_r);
              if (pq_r) begin
                cmd.event_kind = EV_EXPIRE;
                cv_nxt         = 1'b0;
              end else begin
                cmd.event_kind    = EV_WAKE;
                sleep_nxt[pidx_r] = 1'b0;
              end
            end else begin
              wr_data = cd - 1'b1;
            end
          end
          // issue the next read: entries in order, then the current quantum
          if (cnt_r < CNT_QUANT) begin
            rd_en    = 1'b1;
            pend_nxt = 1'b1;
            pq_nxt   = 1'b0;
            pidx_nxt = cnt_r[IDX_W-1:0];
          end else if (cnt_r == CNT_QUANT) begin
            rd_en    = 1'b1;
            rd_addr  = ct_idx;
            pend_nxt = 1'b1;
            pq_nxt   = 1'b1;
            pidx_nxt = ct_idx;
          end else begin
            pend_nxt = 1'b0;
            st_nxt   = ST_DONE;
          end
          if (rd_en) begin
            fwd_nxt      = wr_en && (wr_addr == rd_addr);
            fwd_data_nxt = wr_data;
          end
        end
      end
      ST_DONE: begin
        if (adv) begin
          cmd.fin = 1'b1;
          st_nxt  = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      sleep_r <= '0;
      cv_r    <= 1'b0;
      ct_r    <= '0;
      tick_r  <= '0;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      pq_r    <= 1'b0;
      fwd_r   <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      sleep_r <= sleep_nxt;
      cv_r    <= cv_nxt;
      ct_r    <= ct_nxt;
      tick_r  <= tick_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      pq_r    <= pq_nxt;
      fwd_r   <= fwd_nxt;
    end
    pidx_r     <= pidx_nxt;
    fwd_data_r <= fwd_data_nxt;
  end

endmodule

/* design/sleep_and_quantum_tick_table_core.sv */
// Channel | dir | handshake          | beat payload
// in_     | in  | in_valid/in_stall   | in_t  (opcode, task_id, count_value)
// out_    | out | out_valid/out_stall | out_t (event_kind, event_task, ticks_seen, last)
//
// Sleep, start and idle ticks are handled straight from idle; the result is registered.
// A tick with a current task walks the countdown RAM: one read per entry,
// one for the quantum, one step to flush, then a finishing step.
// Each beat beyond the first of a tick waits for the output register.
// out_stall freezes the walk while a beat waits in the output register;
// reset is synchronous, RAM is not cleared (only written entries are used).
// Depends on sqt_pkg, sqt_ram, sqt_ctrl, sqt_out and the macros header.
`timescale 1ns / 1ps
`include "sleep_and_quantum_tick_table_core_macros.svh"

module sleep_and_quantum_tick_table_core import sqt_pkg::*; #(
  parameter int TASK_COUNT = TASK_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int IDX_W = TASK_COUNT > 1 ? $clog2(TASK_COUNT) : 1;

  cmd_t cmd;
  logic out_adv;
  logic wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [COUNT_W-1:0] wr_data, rd_data;

  sqt_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(TASK_COUNT)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  sqt_ctrl #(
    .TASK_COUNT(TASK_COUNT)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .adv     (out_adv),
    .cmd     (cmd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sqt_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .adv      (out_adv),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  `SQT_ASSERT_NOW(a_cmd_when_free, cmd.push || cmd.fin, out_adv)
  `SQT_ASSERT_NOW(a_cmd_excl, cmd.push, !cmd.fin)
  `SQT_ASSERT_NEXT(a_item_progress, in_valid && !in_stall, out_valid || in_stall)
  `SQT_ASSERT_NOW(a_expire_last, out_valid && out_data.event_kind == EV_EXPIRE, out_data.last)

endmodule

/* tb/sv/tb.sv */
// Self-checking bench for the sleep and quantum tick table core.
// Needs sqt_pkg and sleep_and_quantum_tick_table_core; keeps its own table model.
`timescale 1ns / 1ps

module tb;
  import sqt_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 3000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  sleep_and_quantum_tick_table_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  in_t  op_queue[$];
  out_t expected_events[$];
  int   send_idle_pct = 15;
  int   recv_idle_pct = 62;
  int   beats_queued = 0;
  int   beats_taken = 0;
  int   mismatches = 0;
  int   hold_asks = 0;
  bit   beat_taken = 1'b0;

  // table model state
  bit                   asleep[TASK_COUNT_DEF];
  logic [COUNT_W-1:0]   remaining[TASK_COUNT_DEF];
  bit                   cur_valid = 1'b0;
  logic [TASK_ID_W-1:0] active_id = '0;
  logic [COUNT_W-1:0]   tick_count = '0;

  task automatic push_event(input logic [KIND_W-1:0] kind, input logic [TASK_ID_W-1:0] id);
    out_t ev;
    ev.event_kind = kind;
    ev.event_task = id;
    ev.ticks_seen = tick_count;
    ev.last       = 1'b0;
    expected_events.push_back(ev);
  endtask

  task automatic advance_task_table(input in_t beat);
    int   produced;
    out_t tail;
    produced = 0;
    case (beat.opcode)
      OP_TICK: begin
        tick_count = tick_count + 1;
        if (cur_valid) begin
          for (int i = 0; i < TASK_COUNT_DEF; i++) begin
            if (asleep[i]) begin
              if (remaining[i] <= 1) begin
                remaining[i] = '0;
                asleep[i] = 1'b0;
                push_event(EV_WAKE, TASK_ID_W'(i));
                produced++;
              end else begin
                remaining[i] = remaining[i] - 1;
              end
            end
          end
          if (remaining[active_id] <= 1) begin
            remaining[active_id] = '0;
            cur_valid = 1'b0;
            push_event(EV_EXPIRE, active_id);
            produced++;
          end else begin
            remaining[active_id] = remaining[active_id] - 1;
          end
        end
      end
      OP_SLEEP: begin
        if (cur_valid) begin
          asleep[active_id] = 1'b1;
          remaining[active_id] = beat.count_value;
          cur_valid = 1'b0;
        end
      end
      OP_START: begin
        if (int'(beat.task_id) < TASK_COUNT_DEF) begin
          asleep[beat.task_id] = 1'b0;
          remaining[beat.task_id] = beat.count_value;
          active_id = beat.task_id;
          cur_valid = 1'b1;
        end
      end
      default: ;
    endcase
    if (produced == 0) push_event(EV_ACK, '0);
    tail = expected_events.pop_back();
    tail.last = 1'b1;
    expected_events.push_back(tail);
  endtask

  task automatic add_beat(input logic [OPCODE_W-1:0] op, input logic [TASK_ID_W-1:0] id,
                          input logic [COUNT_W-1:0] cnt);
    in_t beat;
    beat.opcode      = op;
    beat.task_id     = id;
    beat.count_value = cnt;
    op_queue.push_back(beat);
    beats_queued++;
  endtask

  // mostly short countdowns so that wakes and expiries actually happen
  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 70) return COUNT_W'($urandom_range(6));
    if (r < 85) return COUNT_W'($urandom_range(40));
    if (r < 95) return COUNT_W'($urandom);
    case ($urandom_range(3))
      0: return '0;
      1: return COUNT_W'(1);
      2: return COUNT_W'(COUNT_MAX - 1);
      default: return COUNT_MAX;
    endcase
  endfunction

  task automatic add_random_traffic(input int n);
    int added;
    int r;
    int burst;
    logic [COUNT_W-1:0] c;
    added = 0;
    while (added < n) begin
      r = $urandom_range(99);
      if (r < 40) begin
        add_beat(OP_TICK, TASK_ID_W'($urandom), COUNT_W'($urandom));
        added++;
      end else if (r < 60) begin
        // park one task, then hand the slot to another
        add_beat(OP_START, TASK_ID_W'($urandom), pick_count());
        add_beat(OP_SLEEP, TASK_ID_W'($urandom), pick_count());
        add_beat(OP_START, TASK_ID_W'($urandom), pick_count());
        added += 3;
      end else if (r < 78) begin
        add_beat(OP_START, TASK_ID_W'($urandom), pick_count());
        added++;
      end else if (r < 86) begin
        add_beat(OP_SLEEP, TASK_ID_W'($urandom), pick_count());
        added++;
      end else if (r < 91) begin
        add_beat(OP_UNUSED, TASK_ID_W'($urandom), COUNT_W'($urandom));
        added++;
      end else if (r < 97) begin
        burst = $urandom_range(3, 8);
        repeat (burst) add_beat(OP_TICK, TASK_ID_W'($urandom), COUNT_W'($urandom));
        added += burst;
      end else begin
        // every entry asleep with one shared count, then three ticks wake the rest
        c = COUNT_W'($urandom_range(2));
        for (int t = 0; t < TASK_COUNT_DEF; t++) begin
          add_beat(OP_START, TASK_ID_W'(t), pick_count());
          add_beat(OP_SLEEP, TASK_ID_W'($urandom), c);
        end
        add_beat(OP_START, TASK_ID_W'($urandom), COUNT_W'($urandom_range(1)));
        repeat (3) add_beat(OP_TICK, '0, '0);
        added += 2 * TASK_COUNT_DEF + 4;
      end
    end
  endtask

  task automatic wait_for_drain();
    while (beats_taken != beats_queued || expected_events.size() != 0) @(posedge clk);
  endtask

  // input side: a beat stays put until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= op_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    beat_taken = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      beat_taken = 1'b1;
      beats_taken++;
      advance_task_table(in_data);
    end
  end

  // result side stall, with the long hold-off on request
  always @(negedge clk) begin : result_stall
    int hold_left;
    int hold_done;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_done != hold_asks) begin
      hold_done++;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        if (mismatches < 100)
          $display("%0t: unexpected beat: got kind %0d task %0d ticks %0d last %0b",
                   $time, out_data.event_kind, out_data.event_task,
                   out_data.ticks_seen, out_data.last);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        if (out_data.event_kind !== want.event_kind || out_data.event_task !== want.event_task ||
            out_data.ticks_seen !== want.ticks_seen || out_data.last !== want.last) begin
          if (mismatches < 100)
            $display({"%0t: mismatch: expected kind %0d task %0d ticks %0d last %0b,",
                      " got kind %0d task %0d ticks %0d last %0b"},
                     $time, want.event_kind, want.event_task, want.ticks_seen, want.last,
                     out_data.event_kind, out_data.event_task, out_data.ticks_seen,
                     out_data.last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < TASK_COUNT_DEF; i++) begin
      asleep[i] = 1'b0;
      remaining[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle tick, ignored ops, zero counts, wake and expiry together
    add_beat(OP_TICK, 4'd0, '0);
    add_beat(OP_SLEEP, 4'd0, 32'd5);
    add_beat(OP_UNUSED, 4'd15, COUNT_MAX);
    add_beat(OP_START, 4'd0, '0);
    add_beat(OP_TICK, 4'd0, '0);
    add_beat(OP_TICK, 4'd0, '0);
    add_beat(OP_START, 4'd15, COUNT_MAX);
    add_beat(OP_SLEEP, 4'd0, '0);
    add_beat(OP_START, 4'd3, 32'd5);
    add_beat(OP_TICK, 4'd0, '0);
    add_beat(OP_SLEEP, 4'd0, 32'd1);
    add_beat(OP_START, 4'd7, 32'd1);
    add_beat(OP_TICK, 4'd0, '0);
    add_beat(OP_START, 4'd5, 32'd2);
    add_beat(OP_SLEEP, 4'd0, COUNT_MAX);
    add_beat(OP_START, 4'd5, 32'd3);   // cancels the sleep
    add_beat(OP_START, 4'd9, 32'd10);  // 5 keeps its count
    add_beat(OP_TICK, 4'd0, '0);
    add_beat(OP_START, 4'd10, 32'hAAAA_AAAA);
    add_beat(OP_START, 4'd6, 32'h5555_5555);
    add_beat(OP_SLEEP, 4'd0, 32'd2);
    add_beat(OP_START, 4'd8, 32'd2);
    add_beat(OP_TICK, 4'd0, '0);
    add_beat(OP_TICK, 4'd0, '0);
    add_random_traffic(140);
    wait_for_drain();

    send_idle_pct = 62;
    recv_idle_pct = 15;
    add_random_traffic(140);
    wait_for_drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks++;
    add_random_traffic(140);
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/sqt_pkg.sv
design/sqt_ram.sv
design/sqt_out.sv
design/sqt_ctrl.sv
design/sleep_and_quantum_tick_table_core.sv
tb/sv/tb.sv
